// ===== rtl/sorted_set_insert_delete_assert.svh =====
// Assertion macros shared by the sorted set block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SORTED_SET_INSERT_DELETE_ASSERT_SVH
`define SORTED_SET_INSERT_DELETE_ASSERT_SVH

// The condition must never be seen at a clock edge outside reset.
`define SSID_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SSID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ssid_pkg.sv =====
package ssid_pkg;

  // Number of values the table can hold.
  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned OUT_CNT_W = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  // Result of the shared comparator: stored entry against the item value.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// ===== rtl/ssid_ram.sv =====
module ssid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port with a registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ssid_cmp.sv =====
module ssid_cmp
  import ssid_pkg::*;
(
  input  logic signed [VAL_W-1:0] entry_i,
  input  logic signed [VAL_W-1:0] value_i,
  output cmp_res_t                res_o
);

  // Signed compare of a stored entry against the value being looked for.
  always_comb begin
    res_o.lt = (entry_i < value_i);
    res_o.eq = (entry_i == value_i);
  end

endmodule

// ===== rtl/sorted_set_insert_delete.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   op_i, value_i
// result    out        out_valid_o / out_stall_i status_o, count_o, smallest_o, largest_o
//
// An item costs a read and a compare per entry the search visits and a read and a write per
// entry moved, plus acceptance, decision, write and close; the single entry memory port
// sets this. Reset is asynchronous and active low; no clearing pass is needed, since only
// entries below the count are ever used. A result waits in the output register while the
// next item is already accepted; a stalled result holds the block before its next result.
`include "sorted_set_insert_delete_assert.svh"

module sorted_set_insert_delete
  import ssid_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    op_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic [OUT_CNT_W-1:0]    count_o,
  output logic signed [VAL_W-1:0] smallest_o,
  output logic signed [VAL_W-1:0] largest_o
);

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, // waiting for an item
    S_SRD  = 10'b0000000010, // search: read the entry at the index
    S_SCMP = 10'b0000000100, // search: compare the entry with the value
    S_DEC  = 10'b0000001000, // decide what the item does to the table
    S_SHRD = 10'b0000010000, // shift: read the neighbour entry
    S_SHWR = 10'b0000100000, // shift: write it one place along
    S_PUT  = 10'b0001000000, // write the inserted value at its place
    S_ENDA = 10'b0010000000, // read the first entry
    S_ENDB = 10'b0100000000, // capture the smallest, read the last entry
    S_OUT  = 10'b1000000000  // capture the largest and hand the result over
  } state_e;

  state_e                  state_q, state_d;
  logic                    op_q, op_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]        pos_q, pos_d;
  logic                    hit_q, hit_d;
  status_e                 st_q, st_d;
  logic signed [VAL_W-1:0] min_q, min_d;
  logic signed [VAL_W-1:0] max_q, max_d;

  logic                    ov_q, ov_d;
  logic [1:0]              ost_q, ost_d;
  logic [OUT_CNT_W-1:0]    ocnt_q, ocnt_d;
  logic signed [VAL_W-1:0] omin_q, omin_d;
  logic signed [VAL_W-1:0] omax_q, omax_d;

  logic                    ram_we;
  logic [CNT_W-1:0]        ram_idx;
  logic [VAL_W-1:0]        ram_wdata;
  logic [VAL_W-1:0]        ram_rdata;
  cmp_res_t                cmp_res;

  logic                    in_acc;
  logic                    slot_free;
  logic [CNT_W-1:0]        idx_inc;
  logic [CNT_W-1:0]        idx_dec;
  logic [CNT_W-1:0]        nbr_idx;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // The output register can take a new result if it is empty or being emptied now.
  assign slot_free  = !ov_q || !out_stall_i;

  assign idx_inc = idx_q + CNT_W'(1);
  assign idx_dec = idx_q - CNT_W'(1);
  // An insert moves entries up, so it reads the one below; a delete reads the one above.
  assign nbr_idx = (op_q == OP_INSERT) ? idx_dec : idx_inc;

  // The entry table lives in a single-port memory with a registered read.
  ssid_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_idx[ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // The one comparator, reused for every entry visited by the search.
  ssid_cmp u_cmp (
    .entry_i (ram_rdata),
    .value_i (val_q),
    .res_o   (cmp_res)
  );

  // Memory port: which index is addressed and whether it is written.
  always_comb begin
    ram_we    = 1'b0;
    ram_idx   = idx_q;
    ram_wdata = ram_rdata;
    unique case (state_q)
      S_SHRD: begin
        ram_idx = nbr_idx;
      end
      S_SHWR: begin
        ram_we = 1'b1;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_idx   = pos_q;
        ram_wdata = val_q;
      end
      S_ENDA: begin
        ram_idx = '0;
      end
      S_ENDB: begin
        ram_idx = cnt_q - CNT_W'(1);
      end
      S_OUT: begin
        ram_idx = cnt_q - CNT_W'(1);
      end
      default: begin
        ram_idx = idx_q;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    hit_d   = hit_q;
    st_d    = st_q;
    min_d   = min_q;
    max_d   = max_q;
    ov_d    = ov_q && out_stall_i;
    ost_d   = ost_q;
    ocnt_d  = ocnt_q;
    omin_d  = omin_q;
    omax_d  = omax_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d  = op_i;
          val_d = value_i;
          idx_d = '0;
          pos_d = '0;
          hit_d = 1'b0;
          // An empty table needs no search: the place is the first slot.
          state_d = (cnt_q == '0) ? S_DEC : S_SRD;
        end
      end

      S_SRD: begin
        state_d = S_SCMP;
      end

      S_SCMP: begin
        if (cmp_res.lt) begin
          idx_d = idx_inc;
          if (idx_inc == cnt_q) begin
            // Every stored entry is below the value: its place is at the end.
            pos_d   = cnt_q;
            hit_d   = 1'b0;
            state_d = S_DEC;
          end else begin
            state_d = S_SRD;
          end
        end else begin
          pos_d   = idx_q;
          hit_d   = cmp_res.eq;
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        st_d = ST_DONE;
        if (op_q == OP_INSERT) begin
          if (hit_q) begin
            st_d    = ST_DUP;
            state_d = S_ENDA;
          end else if (cnt_q == CNT_W'(CAPACITY)) begin
            st_d    = ST_FULL;
            state_d = S_ENDA;
          end else begin
            // Move entries up from the top down to the insertion place.
            idx_d   = cnt_q;
            state_d = (cnt_q == pos_q) ? S_PUT : S_SHRD;
          end
        end else begin
          if (!hit_q) begin
            st_d    = ST_ABSENT;
            state_d = S_ENDA;
          end else if ((pos_q + CNT_W'(1)) == cnt_q) begin
            // The last entry goes: nothing to move.
            cnt_d   = cnt_q - CNT_W'(1);
            state_d = S_ENDA;
          end else begin
            idx_d   = pos_q;
            state_d = S_SHRD;
          end
        end
      end

      S_SHRD: begin
        state_d = S_SHWR;
      end

      S_SHWR: begin
        if (op_q == OP_INSERT) begin
          idx_d   = idx_dec;
          state_d = (idx_dec == pos_q) ? S_PUT : S_SHRD;
        end else begin
          idx_d = idx_inc;
          if ((idx_q + CNT_W'(2)) == cnt_q) begin
            cnt_d   = cnt_q - CNT_W'(1);
            state_d = S_ENDA;
          end else begin
            state_d = S_SHRD;
          end
        end
      end

      S_PUT: begin
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = S_ENDA;
      end

      S_ENDA: begin
        if (cnt_q == '0) begin
          min_d   = '0;
          max_d   = '0;
          state_d = S_OUT;
        end else begin
          state_d = S_ENDB;
        end
      end

      S_ENDB: begin
        min_d   = ram_rdata;
        state_d = S_OUT;
      end

      S_OUT: begin
        // The read of the last entry issued in the previous state lands now,
        // unless the table is empty and both ends were already set to zero.
        if (slot_free) begin
          ov_d    = 1'b1;
          ost_d   = st_q;
          ocnt_d  = OUT_CNT_W'(cnt_q);
          omin_d  = min_q;
          omax_d  = (cnt_q == '0) ? max_q : ram_rdata;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // While S_OUT waits, the port keeps reading the last entry, so the largest
  // value stays on the read data.

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    val_q  <= val_d;
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    hit_q  <= hit_d;
    st_q   <= st_d;
    min_q  <= min_d;
    max_q  <= max_d;
    ost_q  <= ost_d;
    ocnt_q <= ocnt_d;
    omin_q <= omin_d;
    omax_q <= omax_d;
  end

  assign out_valid_o = ov_q;
  assign status_o    = ost_q;
  assign count_o     = ocnt_q;
  assign smallest_o  = omin_q;
  assign largest_o   = omax_q;

  // The count never passes the capacity of the table.
  `SSID_ASSERT_NEVER(a_cnt_bound, cnt_q > CNT_W'(CAPACITY), "entry count above capacity")

  // An insert write only happens with room left and at a place within the stored range.
  `SSID_ASSERT_IMP(a_put_room, state_q == S_PUT,
    (cnt_q < CNT_W'(CAPACITY)) && (pos_q <= cnt_q), "insert write without room")

  // A handed-over result of a non-empty table keeps its ends in order.
  `SSID_ASSERT_IMP(a_ends_order, ov_q && (cnt_q != '0) && $rose(ov_q),
    omin_q <= omax_q, "smallest above largest")

  // An accepted item always starts work in the sequencer.
  `SSID_ASSERT_NEXT(a_acc_busy, in_acc, state_q != S_IDLE, "accepted item left idle")

endmodule

// ===== bench/sorted_set_insert_delete_test.sv =====
module sorted_set_insert_delete_test;
  import ssid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The block walks its entry memory one word at a time, so an item takes longer
  // the more entries are stored. The settle time at the end allows twice the
  // longest item; the watchdog allows far more.
  localparam int unsigned SETTLE_CYCLES = 4 * CAPACITY + 16;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;

  // One result as the block should report it.
  typedef struct {
    status_e                 status;
    logic [OUT_CNT_W-1:0]    count;
    logic signed [VAL_W-1:0] smallest;
    logic signed [VAL_W-1:0] largest;
  } set_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    op_i = OP_INSERT;
  logic signed [VAL_W-1:0] value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [1:0]              status_o;
  logic [OUT_CNT_W-1:0]    count_o;
  logic signed [VAL_W-1:0] smallest_o;
  logic signed [VAL_W-1:0] largest_o;

  // Our own copy of the sorted set, kept in ascending order, and the results
  // that accepted items have still to produce, oldest first.
  logic signed [VAL_W-1:0] held_values[$];
  set_result_t             pending_results[$];

  // Idling odds out of a hundred for each side, and the length of a forced
  // hold-off on the result side, which the receiver counts down itself.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  sorted_set_insert_delete dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .count_o    (count_o),
    .smallest_o (smallest_o),
    .largest_o  (largest_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one item to our copy of the set and returns the result it causes.
  // A duplicate insert is recognised before the full check, so a full table
  // still reports a duplicate when the value is already there.
  function automatic set_result_t update_set(op_e op, logic signed [VAL_W-1:0] v);
    set_result_t r;
    int          pos;
    bit          hit;
    pos = 0;
    while (pos < held_values.size() && held_values[pos] < v) pos++;
    hit = (pos < held_values.size()) && (held_values[pos] == v);
    r.status = ST_DONE;
    if (op == OP_INSERT) begin
      if (hit) begin
        r.status = ST_DUP;
      end else if (held_values.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        held_values.insert(pos, v);
      end
    end else if (hit) begin
      held_values.delete(pos);
    end else begin
      r.status = ST_ABSENT;
    end
    r.count = OUT_CNT_W'(held_values.size());
    if (held_values.size() != 0) begin
      r.smallest = held_values[0];
      r.largest  = held_values[held_values.size() - 1];
    end else begin
      // An empty set reports zero for both bounds.
      r.smallest = '0;
      r.largest  = '0;
    end
    return r;
  endfunction

  // Picks a value that is often already stored, so that deletes hit and
  // inserts run into duplicates, with small values and the extremes of the
  // range mixed in, and otherwise a fully random word so every bit toggles.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40 && held_values.size() != 0)
      return held_values[$urandom_range(held_values.size() - 1)];
    if (roll < 55)
      return int'($urandom_range(16)) - 8;
    if (roll < 60) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh8000_0001;
        default: return 32'sh7FFF_FFFE;
      endcase
    end
    return $urandom;
  endfunction

  function automatic void check_field(string field, logic signed [VAL_W:0] want,
                                      logic signed [VAL_W:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Offers one item, after a random idle gap, and holds it until the block
  // takes it. Valid is left high on return so that back-to-back items keep it
  // high; whoever sends next, or stops sending, decides at the next falling
  // edge. The expectation is worked out at the edge of acceptance.
  task automatic send_item(op_e op, logic signed [VAL_W-1:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(update_set(op, v));
  endtask

  // Stops offering items and waits until every expected result has arrived.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Short hand-written sequence: delete on an empty set, both ends of the
  // value range, duplicates, absent values and emptying the set again.
  task automatic test_directed();
    send_item(OP_DELETE, 32'sd5);
    send_item(OP_INSERT, 32'sd0);
    send_item(OP_INSERT, 32'sh8000_0000);
    send_item(OP_INSERT, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, -32'sd1);
    send_item(OP_INSERT, 32'sd1);
    send_item(OP_INSERT, 32'sh8000_0000);
    send_item(OP_INSERT, 32'sh7FFF_FFFF);
    send_item(OP_DELETE, 32'sd7);
    send_item(OP_DELETE, 32'sh8000_0000);
    send_item(OP_DELETE, 32'sh7FFF_FFFF);
    send_item(OP_DELETE, 32'sd0);
    send_item(OP_INSERT, 32'sh5A5A_5A5A);
    send_item(OP_INSERT, 32'shA5A5_A5A5);
    send_item(OP_DELETE, -32'sd1);
    send_item(OP_DELETE, 32'sd1);
    send_item(OP_DELETE, 32'sh5A5A_5A5A);
    send_item(OP_DELETE, 32'shA5A5_A5A5);
    send_item(OP_DELETE, 32'sd1);
    send_item(OP_INSERT, 32'sh8000_0000);
    send_item(OP_DELETE, 32'sh8000_0000);
  endtask

  // Fills the set to capacity with random words, then tries a duplicate, a
  // fresh value and the extremes against the full set, deletes an absent
  // value, and finally empties it again in random order.
  task automatic test_full_table();
    logic signed [VAL_W-1:0] v;
    while (held_values.size() < CAPACITY) send_item(OP_INSERT, $urandom);
    send_item(OP_INSERT, held_values[$urandom_range(CAPACITY - 1)]);
    do v = $urandom; while (v inside {held_values});
    send_item(OP_INSERT, v);
    send_item(OP_DELETE, v);
    if (!(32'sh8000_0000 inside {held_values})) send_item(OP_INSERT, 32'sh8000_0000);
    if (!(32'sh7FFF_FFFF inside {held_values})) send_item(OP_INSERT, 32'sh7FFF_FFFF);
    while (held_values.size() != 0)
      send_item(OP_DELETE, held_values[$urandom_range(held_values.size() - 1)]);
  endtask

  // Random traffic that swings the set between empty and full: while filling,
  // three items in four are inserts; while draining, three in four deletes.
  // One item in ten ignores the trend entirely.
  task automatic run_random_items(int unsigned n);
    bit  filling;
    op_e op;
    filling = 1'b1;
    repeat (n) begin
      if (held_values.size() >= CAPACITY) filling = 1'b0;
      if (held_values.size() == 0) filling = 1'b1;
      if ($urandom_range(99) < 3) filling = !filling;
      if ($urandom_range(9) == 0)
        op = op_e'($urandom_range(1));
      else
        op = (($urandom_range(3) != 0) == filling) ? OP_INSERT : OP_DELETE;
      send_item(op, pick_value());
    end
  endtask

  // The four idling mixes: none, sender only, receiver only, and both sides.
  task automatic test_idling_phases();
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random_items(400);
    send_idle_pct = 57;
    run_random_items(400);
    send_idle_pct = 0;
    stall_pct     = 57;
    run_random_items(400);
    send_idle_pct = 20;
    stall_pct     = 20;
    run_random_items(400);
  endtask

  // The receiver holds off for a long stretch while the sender keeps going
  // flat out, so results back up inside the block and it stalls its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 300;
    run_random_items(40);
  endtask

  // The sender goes quiet until every result is in, then starts again.
  task automatic test_pause_until_drained();
    stall_pct = 30;
    run_random_items(20);
    wait_for_results();
    run_random_items(20);
  endtask

  // Result side: stalls at random, or for the whole of a hold-off.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every result the block hands over is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    set_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, status %0d count %0d", $time,
                 status_o, count_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("count", want.count, count_o);
        check_field("smallest", want.smallest, smallest_o);
        check_field("largest", want.largest, largest_o);
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_set_insert_delete verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_full_table();
    test_idling_phases();
    test_backpressure();
    test_pause_until_drained();

    // Let everything outstanding come out, then give any stray result time
    // to show itself before the verdict.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("sorted_set_insert_delete verification clean");
    end else begin
      $display("sorted_set_insert_delete verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ssid_pkg.sv
rtl/ssid_ram.sv
rtl/ssid_cmp.sv
rtl/sorted_set_insert_delete.sv
bench/sorted_set_insert_delete_test.sv
